@@ rtl/core/arp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and constants of the ARP resolver cache.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int TABLE_ENTRIES   = 16;
  localparam int PENDING_ENTRIES = 8;
  localparam int SCAN_MAX = (TABLE_ENTRIES > PENDING_ENTRIES) ? TABLE_ENTRIES : PENDING_ENTRIES;
  localparam int TIDX_W = $clog2(TABLE_ENTRIES);
  localparam int PIDX_W = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int TCNT_W = $clog2(SCAN_MAX + 1);

  localparam logic [10:0] ARP_MIN_LEN  = 11'(2 + 2 + 1 + 1 + 2);
  localparam logic [15:0] HW_ETHERNET  = 16'h0001;
  localparam logic [15:0] PROTO_IPV4   = 16'h0800;
  localparam logic [7:0]  HW_ADDR_LEN  = 8'd6;
  localparam logic [7:0]  IP_ADDR_LEN  = 8'd4;
  localparam logic [15:0] OPC_REQUEST  = 16'd1;
  localparam logic [15:0] OPC_REPLY    = 16'd2;
  localparam logic [15:0] AGE_MAX      = 16'hFFFF;
  localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] OP_ARP  = 2'd0;
  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] ACT_FORWARD = 2'd0;
  localparam logic [1:0] ACT_REQUEST = 2'd1;
  localparam logic [1:0] ACT_REPLY   = 2'd2;

  localparam logic [1:0] REG_OWN_IP   = 2'd0;
  localparam logic [1:0] REG_OWN_MAC  = 2'd1;
  localparam logic [1:0] REG_ENT_LIFE = 2'd2;
  localparam logic [1:0] REG_PND_LIFE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TSCAN,
    ST_PSCAN,
    ST_DECIDE,
    ST_MACRD,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/arp_resolver_cache.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_resolver_cache
// IPv4-over-Ethernet ARP resolver with learned table and waiting packets.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_stall carry one item (ARP received, outbound packet, tick).
//  - out_valid/out_stall carry zero or one result per item.
//  - cfg_valid/cfg_ready write own_ip, own_mac and the two lifetimes; cfg
//    writes are always taken.
//  - Items are handled one at a time. The scan walks the 16 entry table
//    memory one address per cycle, then the 8 entry pending memory; the one
//    read per cycle of these memories sets the timing.
//  - A result is registered after the table scan, the pending scan and the
//    decide and output steps; a table hit adds a step to read the mac.
//  - Without receiver stalls the next item is taken once the last is done: a
//    tick after the pending scan, an item with no result after the decide
//    step; a malformed ARP item or an unknown op is dropped and the next item
//    can follow in the next cycle.
//  - A result sits in the output register until transferred; in_stall is
//    high while an item is in work or its result waits, so each stalled
//    cycle delays the next item.
//  - Reset clears all valid bits and the fsm; entry contents need no reset.
// ----------------------------------------------------------------------------
module arp_resolver_cache
  import arp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [10:0] frame_length,
  input  wire logic [15:0] hw_type,
  input  wire logic [15:0] proto_type,
  input  wire logic [7:0]  hw_len,
  input  wire logic [7:0]  proto_len,
  input  wire logic [15:0] arp_opcode,
  input  wire logic [31:0] src_ip,
  input  wire logic [47:0] src_mac,
  input  wire logic [31:0] dst_ip,
  input  wire logic [7:0]  packet_tag,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  action,
  output      logic [47:0] dest_mac,
  output      logic [31:0] out_ip,
  output      logic [7:0]  out_tag,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  // configuration registers
  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [15:0] entry_lifetime;
  logic [15:0] pending_lifetime;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip           <= '0;
      own_mac          <= '0;
      entry_lifetime   <= 16'd60;
      pending_lifetime <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OWN_IP:   own_ip           <= cfg_data[31:0];
        REG_OWN_MAC:  own_mac          <= cfg_data;
        REG_ENT_LIFE: entry_lifetime   <= cfg_data[15:0];
        REG_PND_LIFE: pending_lifetime <= cfg_data[15:0];
      endcase
    end
  end

  // memories: table key+age in one, table mac in another, pending key+tag+age in a third; valid bits in flops
  logic [47:0] t_ipage_mem [TABLE_ENTRIES];
  logic [47:0] t_mac_mem   [TABLE_ENTRIES];
  logic [55:0] p_mem       [PENDING_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   t_vld;
  logic [PENDING_ENTRIES-1:0] p_vld;

  logic [47:0] t_rd;
  logic [47:0] t_mac_rd;
  logic [55:0] p_rd;

  // latched item
  logic [1:0]  i_op;
  logic        i_good;
  logic        i_req;
  logic [31:0] i_sip;
  logic [47:0] i_smac;
  logic [31:0] i_tip;
  logic [7:0]  i_tag;

  state_t state, state_next;
  logic [TCNT_W-1:0] cnt;
  logic              rd_vld;
  logic [TCNT_W-1:0] rd_idx;

  // scan results
  logic              t_hit, p_hit, t_free, p_free;
  logic [TIDX_W-1:0] t_hit_idx, t_sel;
  logic [PIDX_W-1:0] p_hit_idx, p_sel;
  logic [15:0]       t_best_age, p_best_age;
  logic [7:0]        p_hit_tag;

  // read addresses driven by scan counter (hit index in decide), and write controls
  logic [TIDX_W-1:0] t_raddr;
  logic [PIDX_W-1:0] p_raddr;
  logic              t_wen, p_wen, tm_wen;
  logic [TIDX_W-1:0] t_waddr;
  logic [PIDX_W-1:0] p_waddr;
  logic [47:0]       t_wdata;
  logic [55:0]       p_wdata;

  always_ff @(posedge clk) begin
    t_rd     <= t_ipage_mem[t_raddr];
    t_mac_rd <= t_mac_mem[t_raddr];
    p_rd     <= p_mem[p_raddr];
    if (t_wen)  t_ipage_mem[t_waddr] <= t_wdata;
    if (tm_wen) t_mac_mem[t_waddr]   <= i_smac;
    if (p_wen)  p_mem[p_waddr]       <= p_wdata;
  end

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE) || out_valid;

  logic good_arp;
  assign good_arp = !(frame_length < ARP_MIN_LEN) && hw_type == HW_ETHERNET &&
                    proto_type == PROTO_IPV4 && hw_len == HW_ADDR_LEN &&
                    proto_len == IP_ADDR_LEN &&
                    (arp_opcode == OPC_REQUEST || arp_opcode == OPC_REPLY);

  logic [31:0] key;
  assign key = (i_op == OP_ARP) ? i_sip : i_tip;

  // aging of the entry just read
  logic [15:0] t_age_inc, p_age_inc;
  assign t_age_inc = (t_rd[15:0] == AGE_MAX) ? AGE_MAX : t_rd[15:0] + 16'd1;
  assign p_age_inc = (p_rd[15:0] == AGE_MAX) ? AGE_MAX : p_rd[15:0] + 16'd1;

  logic [TIDX_W-1:0] t_ridx;
  logic [PIDX_W-1:0] p_ridx;
  assign t_ridx = rd_idx[TIDX_W-1:0];
  assign p_ridx = PIDX_W'(rd_idx);

  // next state and memory control
  always_comb begin
    state_next = state;
    t_raddr = cnt[TIDX_W-1:0];
    p_raddr = PIDX_W'(cnt);
    t_wen = 1'b0; tm_wen = 1'b0; p_wen = 1'b0;
    t_waddr = t_ridx; p_waddr = p_ridx;
    t_wdata = {t_rd[47:16], t_age_inc};
    p_wdata = {p_rd[55:16], p_age_inc};
    unique case (state)
      ST_IDLE: begin
        t_raddr = '0;
        p_raddr = '0;
        if (accept) begin
          if (op == OP_TICK || op == OP_SEND || (op == OP_ARP && good_arp))
            state_next = ST_TSCAN;
        end
      end
      ST_TSCAN: begin
        if (i_op == OP_TICK && rd_vld && t_vld[t_ridx]) t_wen = 1'b1;
        if (cnt == TCNT_W'(TABLE_ENTRIES)) begin
          p_raddr = '0;
          state_next = ST_PSCAN;
        end
      end
      ST_PSCAN: begin
        if (i_op == OP_TICK && rd_vld && p_vld[p_ridx]) p_wen = 1'b1;
        if (cnt == TCNT_W'(PENDING_ENTRIES)) begin
          state_next = (i_op == OP_TICK) ? ST_IDLE : ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        t_raddr = t_hit_idx;
        if (i_op == OP_ARP) begin
          t_wen = 1'b1; tm_wen = 1'b1;
          t_waddr = t_hit ? t_hit_idx : t_sel;
          t_wdata = {i_sip, 16'd0};
          state_next = (p_hit || (i_req && i_tip == own_ip)) ? ST_OUT : ST_IDLE;
        end else if (t_hit) begin
          state_next = ST_MACRD;
        end else if (p_hit) begin
          state_next = ST_IDLE;
        end else begin
          p_wen = 1'b1;
          p_waddr = p_sel;
          p_wdata = {i_tip, i_tag, 16'd0};
          state_next = ST_OUT;
        end
      end
      ST_MACRD: state_next = ST_OUT;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control and scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      t_vld  <= '0;
      p_vld  <= '0;
      cnt    <= '0;
      rd_vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // result valid rises after the output step and holds until transfer
      if (state == ST_OUT) out_valid <= i_good || (i_op == OP_SEND);
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (accept) begin
          i_op <= op; i_good <= good_arp; i_req <= (arp_opcode == OPC_REQUEST);
          i_sip <= src_ip; i_smac <= src_mac; i_tip <= dst_ip;
          i_tag <= packet_tag;
          cnt <= TCNT_W'(1); rd_vld <= 1'b1; rd_idx <= '0;
          t_hit <= 1'b0; p_hit <= 1'b0; t_free <= 1'b0; p_free <= 1'b0;
          t_sel <= '0; p_sel <= '0; t_best_age <= '0; p_best_age <= '0;
          t_hit_idx <= '0; p_hit_idx <= '0; p_hit_tag <= '0;
        end
        ST_TSCAN: begin
          if (rd_vld) begin
            if (i_op == OP_TICK) begin
              if (t_vld[t_ridx] && t_age_inc >= entry_lifetime) t_vld[t_ridx] <= 1'b0;
            end else if (!t_vld[t_ridx]) begin
              if (!t_free) begin t_free <= 1'b1; t_sel <= t_ridx; end
            end else begin
              if (!t_hit && t_rd[47:16] == key) begin
                t_hit <= 1'b1; t_hit_idx <= t_ridx;
              end
              if (!t_free && (t_ridx == '0 || t_rd[15:0] > t_best_age)) begin
                t_sel <= t_ridx; t_best_age <= t_rd[15:0];
              end
            end
          end
          if (cnt == TCNT_W'(TABLE_ENTRIES)) begin
            cnt <= TCNT_W'(1); rd_vld <= 1'b1; rd_idx <= '0;
          end else begin
            cnt <= cnt + 1'b1; rd_vld <= 1'b1; rd_idx <= cnt;
          end
        end
        ST_PSCAN: begin
          if (rd_vld) begin
            if (i_op == OP_TICK) begin
              if (p_vld[p_ridx] && p_age_inc >= pending_lifetime) p_vld[p_ridx] <= 1'b0;
            end else if (!p_vld[p_ridx]) begin
              if (!p_free) begin p_free <= 1'b1; p_sel <= p_ridx; end
            end else begin
              if (!p_hit && p_rd[55:24] == key) begin
                p_hit <= 1'b1; p_hit_idx <= p_ridx; p_hit_tag <= p_rd[23:16];
              end
              if (!p_free && (p_ridx == '0 || p_rd[15:0] > p_best_age)) begin
                p_sel <= p_ridx; p_best_age <= p_rd[15:0];
              end
            end
          end
          if (cnt == TCNT_W'(PENDING_ENTRIES)) begin
            cnt <= '0; rd_vld <= 1'b0;
          end else begin
            cnt <= cnt + 1'b1; rd_vld <= 1'b1; rd_idx <= cnt;
          end
        end
        ST_DECIDE: begin
          if (i_op == OP_ARP) begin
            t_vld[t_hit ? t_hit_idx : t_sel] <= 1'b1;
            if (p_hit) begin
              p_vld[p_hit_idx] <= 1'b0;
              action <= ACT_FORWARD; dest_mac <= i_smac; out_ip <= '0;
              out_tag <= p_hit_tag;
            end else begin
              action <= ACT_REPLY; dest_mac <= i_smac; out_ip <= i_sip;
              out_tag <= '0;
            end
          end else if (!t_hit && !p_hit) begin
            p_vld[p_sel] <= 1'b1;
            action <= ACT_REQUEST; dest_mac <= MAC_BCAST; out_ip <= i_tip;
            out_tag <= '0;
          end
        end
        ST_MACRD: begin
          action <= ACT_FORWARD; dest_mac <= t_mac_rd; out_ip <= '0; out_tag <= i_tag;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/arp_resolver_cache_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_resolver_cache_checker
// Port-level checks of the ARP resolver cache.
// ----------------------------------------------------------------------------
module arp_resolver_cache_checker
  import arp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  action,
  input wire logic [47:0] dest_mac,
  input wire logic [7:0]  out_tag,
  input wire logic        cfg_ready
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(action) && $stable(dest_mac))
    else $error("stalled result changed");

  // no input taken while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // a request goes to broadcast with no tag
  a_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_REQUEST |-> dest_mac == MAC_BCAST && out_tag == 8'd0)
    else $error("bad request fields");

  // a result only comes from an item in work
  a_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised with input open");

  // config always accepted
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config not ready");

endmodule

bind arp_resolver_cache arp_resolver_cache_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .action(action),
  .dest_mac(dest_mac), .out_tag(out_tag), .cfg_ready(cfg_ready)
);
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ARP resolver cache: a directed table of items,
// then random traffic built from learn/send/tick sequences, with results
// checked against a behavioral copy of the resolver.
// ----------------------------------------------------------------------------
module testbench;
  import arp_pkg::*;

  localparam int PERIOD     = 4;
  localparam int ITEM_CYCLES = 40;

  typedef struct {
    logic [1:0]  op;
    logic [10:0] flen;
    logic [15:0] hwt;
    logic [15:0] prt;
    logic [7:0]  hwl;
    logic [7:0]  prl;
    logic [15:0] opc;
    logic [31:0] sip;
    logic [47:0] smac;
    logic [31:0] tip;
    logic [7:0]  tag;
  } arp_item_t;

  typedef struct packed {
    logic [1:0]  act;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [7:0]  tag;
  } arp_result_t;

  typedef struct {
    arp_item_t   item;
    bit          typed;   // expected result written in the row
    bit          has_res;
    arp_result_t res;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] op = '0;
  logic [10:0] frame_length = '0;
  logic [15:0] hw_type = '0, proto_type = '0, arp_opcode = '0;
  logic [7:0] hw_len = '0, proto_len = '0, packet_tag = '0;
  logic [31:0] src_ip = '0, dst_ip = '0;
  logic [47:0] src_mac = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] action;
  logic [47:0] dest_mac;
  logic [31:0] out_ip;
  logic [7:0] out_tag;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  arp_resolver_cache uut (.*);

  always #(PERIOD / 2) clk = ~clk;

  // predictor state
  logic [31:0] m_own_ip;
  logic [15:0] m_ent_life, m_pnd_life;
  bit          t_vld[TABLE_ENTRIES];
  logic [31:0] t_ip[TABLE_ENTRIES];
  logic [47:0] t_mac[TABLE_ENTRIES];
  logic [15:0] t_age[TABLE_ENTRIES];
  bit          p_vld[PENDING_ENTRIES];
  logic [31:0] p_ip[PENDING_ENTRIES];
  logic [7:0]  p_tag[PENDING_ENTRIES];
  logic [15:0] p_age[PENDING_ENTRIES];

  arp_result_t expected_results[$];
  int  errors = 0;
  bit  hold_off = 0;
  bit  drained = 0;

  function automatic int find_table(logic [31:0] ip);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (t_vld[i] && t_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic int find_pending(logic [31:0] ip);
    for (int i = 0; i < PENDING_ENTRIES; i++)
      if (p_vld[i] && p_ip[i] == ip) return i;
    return -1;
  endfunction

  // lowest free slot, else oldest with lowest index on ties
  function automatic int victim_table();
    int b;
    b = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (!t_vld[i]) return i;
    for (int i = 1; i < TABLE_ENTRIES; i++)
      if (t_age[i] > t_age[b]) b = i;
    return b;
  endfunction

  function automatic int victim_pending();
    int b;
    b = 0;
    for (int i = 0; i < PENDING_ENTRIES; i++)
      if (!p_vld[i]) return i;
    for (int i = 1; i < PENDING_ENTRIES; i++)
      if (p_age[i] > p_age[b]) b = i;
    return b;
  endfunction

  // resolver behavior for one item; returns 1 when a result is produced
  function automatic bit resolve_item(arp_item_t it, output arp_result_t r);
    int s;
    r = '{ACT_FORWARD, '0, '0, '0};
    if (it.op == OP_ARP) begin
      if (it.flen < ARP_MIN_LEN || it.hwt != HW_ETHERNET || it.prt != PROTO_IPV4 ||
          it.hwl != HW_ADDR_LEN || it.prl != IP_ADDR_LEN ||
          (it.opc != OPC_REQUEST && it.opc != OPC_REPLY)) return 0;
      s = find_table(it.sip);
      if (s < 0) s = victim_table();
      t_vld[s] = 1; t_ip[s] = it.sip; t_mac[s] = it.smac; t_age[s] = '0;
      s = find_pending(it.sip);
      if (s >= 0) begin
        p_vld[s] = 0;
        r = '{ACT_FORWARD, it.smac, '0, p_tag[s]};
        return 1;
      end
      if (it.opc == OPC_REQUEST && it.tip == m_own_ip) begin
        r = '{ACT_REPLY, it.smac, it.sip, '0};
        return 1;
      end
      return 0;
    end
    if (it.op == OP_SEND) begin
      s = find_table(it.tip);
      if (s >= 0) begin
        r = '{ACT_FORWARD, t_mac[s], '0, it.tag};
        return 1;
      end
      if (find_pending(it.tip) >= 0) return 0;
      s = victim_pending();
      p_vld[s] = 1; p_ip[s] = it.tip; p_tag[s] = it.tag; p_age[s] = '0;
      r = '{ACT_REQUEST, MAC_BCAST, it.tip, '0};
      return 1;
    end
    if (it.op == OP_TICK) begin
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (t_vld[i]) begin
          if (t_age[i] != AGE_MAX) t_age[i]++;
          if (t_age[i] >= m_ent_life) t_vld[i] = 0;
        end
      for (int i = 0; i < PENDING_ENTRIES; i++)
        if (p_vld[i]) begin
          if (p_age[i] != AGE_MAX) p_age[i]++;
          if (p_age[i] >= m_pnd_life) p_vld[i] = 0;
        end
    end
    return 0;
  endfunction

  function automatic arp_item_t good_arp(logic [15:0] opc, logic [31:0] sip,
                                         logic [47:0] smac, logic [31:0] tip);
    arp_item_t it;
    it = '{OP_ARP, ARP_MIN_LEN, HW_ETHERNET, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN,
           opc, sip, smac, tip, 8'($urandom)};
    return it;
  endfunction

  function automatic arp_item_t send_item(logic [31:0] tip, logic [7:0] tag);
    arp_item_t it;
    it = '{OP_SEND, 11'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
           8'($urandom), 16'($urandom), $urandom, {16'($urandom), 32'($urandom)},
           tip, tag};
    return it;
  endfunction

  function automatic arp_item_t tick_item();
    arp_item_t it;
    it = send_item($urandom, 8'($urandom));
    it.op = OP_TICK;
    return it;
  endfunction

  // one configuration register write, predictor updated alongside
  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OWN_IP:   m_own_ip = val[31:0];
      REG_ENT_LIFE: m_ent_life = val[15:0];
      REG_PND_LIFE: m_pnd_life = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // offer one item until transfer; predictor runs on acceptance
  task automatic send_one(arp_item_t it, bit typed, bit has_res, arp_result_t want);
    arp_result_t r;
    bit got;
    in_valid <= 1;
    op <= it.op; frame_length <= it.flen; hw_type <= it.hwt; proto_type <= it.prt;
    hw_len <= it.hwl; proto_len <= it.prl; arp_opcode <= it.opc;
    src_ip <= it.sip; src_mac <= it.smac; dst_ip <= it.tip;
    packet_tag <= it.tag;
    do @(posedge clk); while (in_stall);
    got = resolve_item(it, r);
    if (typed && (got != has_res || (got && r != want))) begin
      $error("directed row disagrees with predictor: op %0d", it.op);
      errors++;
    end
    if (got) expected_results.push_back(r);
    @(negedge clk);
  endtask

  // sender with bursts and gaps
  task automatic offer(arp_item_t it);
    arp_result_t none;
    none = '{ACT_FORWARD, '0, '0, '0};
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    send_one(it, 0, 0, none);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (ITEM_CYCLES) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    arp_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: action %0d", action);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (action !== e.act) begin
          $error("action: expected %0d, actual %0d", e.act, action); errors++;
        end
        if (dest_mac !== e.mac) begin
          $error("dest_mac: expected %h, actual %h", e.mac, dest_mac); errors++;
        end
        if (out_ip !== e.ip) begin
          $error("out_ip: expected %h, actual %h", e.ip, out_ip); errors++;
        end
        if (out_tag !== e.tag) begin
          $error("out_tag: expected %h, actual %h", e.tag, out_tag); errors++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else if (drained) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    #(PERIOD * 3_000_000);
    $display("** arp_resolver_cache: FAILED **");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    arp_item_t it;
    arp_result_t none;
    logic [31:0] ips[8];
    int k;
    none = '{ACT_FORWARD, '0, '0, '0};
    m_own_ip = '0; m_ent_life = 16'd60; m_pnd_life = 16'd1;
    for (int i = 0; i < TABLE_ENTRIES; i++) t_vld[i] = 0;
    for (int i = 0; i < PENDING_ENTRIES; i++) p_vld[i] = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    write_reg(REG_OWN_IP, 48'h0000_0A00_0001);
    write_reg(REG_OWN_MAC, 48'h0200_0000_0001);
    write_reg(REG_PND_LIFE, 48'd3);

    // directed rows
    it = send_item(32'h0A00_0005, 8'h11);
    rows.push_back('{it, 1, 1, '{ACT_REQUEST, MAC_BCAST, 32'h0A00_0005, 8'h00}});
    it = send_item(32'h0A00_0005, 8'h22);                  // already parked
    rows.push_back('{it, 1, 0, none});
    it = good_arp(OPC_REPLY, 32'h0A00_0005, 48'hAABB_CCDD_EEFF, 32'h0A00_0001);
    rows.push_back('{it, 1, 1, '{ACT_FORWARD, 48'hAABB_CCDD_EEFF, 32'h0, 8'h11}});
    it = good_arp(OPC_REQUEST, 32'hC0A8_0102, 48'h1234_5678_9ABC, 32'h0A00_0001);
    rows.push_back('{it, 1, 1, '{ACT_REPLY, 48'h1234_5678_9ABC, 32'hC0A8_0102, 8'h0}});
    it = send_item(32'hC0A8_0102, 8'hFF);
    rows.push_back('{it, 1, 1, '{ACT_FORWARD, 48'h1234_5678_9ABC, 32'h0, 8'hFF}});
    it = good_arp(OPC_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0A00_0002);
    rows.push_back('{it, 1, 0, none});                      // not for us
    it = good_arp(OPC_REPLY, 32'h0, 48'h0, 32'h0A00_0001);
    rows.push_back('{it, 1, 0, none});                      // reply never answered
    // malformed variants
    for (int m = 0; m < 7; m++) begin
      it = good_arp(OPC_REQUEST, 32'h0A00_0063, 48'h0101_0101_0101, 32'h0A00_0001);
      case (m)
        0: it.flen = 11'd7;
        1: it.hwt = 16'hFFFF;
        2: it.prt = 16'h86DD;
        3: it.hwl = 8'hFF;
        4: it.prl = 8'd0;
        5: it.opc = 16'd0;
        default: it.opc = 16'hFFFF;
      endcase
      rows.push_back('{it, 1, 0, none});
    end
    it = good_arp(OPC_REQUEST, 32'h0A00_0063, 48'h0101_0101_0101, 32'h0A00_0001);
    it.flen = 11'h7FF;
    rows.push_back('{it, 0, 0, none});
    it = send_item(32'h0A00_0063, 8'h5A);
    rows.push_back('{it, 0, 0, none});
    it = tick_item();
    rows.push_back('{it, 1, 0, none});
    it = tick_item(); it.op = 2'd3;                         // unknown op
    rows.push_back('{it, 1, 0, none});
    it = send_item(32'h0A00_0077, 8'h01);
    rows.push_back('{it, 0, 0, none});
    for (int t = 0; t < 3; t++) begin                        // waiting packet expires
      it = tick_item();
      rows.push_back('{it, 0, 0, none});
    end
    it = good_arp(OPC_REPLY, 32'h0A00_0077, 48'h0000_0000_0077, 32'h0);
    rows.push_back('{it, 0, 0, none});

    foreach (rows[i]) send_one(rows[i].item, rows[i].typed, rows[i].has_res, rows[i].res);
    wait_idle();

    // random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_ENT_LIFE, 48'd4); write_reg(REG_PND_LIFE, 48'd2); end
        1: begin write_reg(REG_ENT_LIFE, 48'hFFFF); write_reg(REG_PND_LIFE, 48'hFFFF); end
        2: begin write_reg(REG_ENT_LIFE, 48'd1); write_reg(REG_PND_LIFE, 48'd1); end
        3: begin write_reg(REG_ENT_LIFE, 48'd0); write_reg(REG_PND_LIFE, 48'd0); end
        default: begin write_reg(REG_ENT_LIFE, 48'd30); write_reg(REG_PND_LIFE, 48'd6); end
      endcase
      write_reg(REG_OWN_IP, (ph == 1) ? 48'hFFFF_FFFF : 48'($urandom));
      write_reg(REG_OWN_MAC, (ph == 1) ? 48'hFFFF_FFFF_FFFF : 48'(ph));
      // small address pool so hits, misses and replacements all occur
      for (int i = 0; i < 8; i++) ips[i] = (i < 2) ? m_own_ip + 32'(i) : $urandom;
      if (ph == 1) begin
        ips[2] = 32'h0; ips[3] = 32'hFFFF_FFFF;
      end
      // long receiver hold-off while the sender keeps offering
      if (ph == 2) fork
        begin
          hold_off = 1;
          repeat (300) @(negedge clk);
          hold_off = 0;
        end
      join_none
      for (int n = 0; n < 80; n++) begin
        k = $urandom_range(0, 9);
        if (k < 3)
          it = send_item(ips[$urandom_range(0, 7)], 8'($urandom));
        else if (k < 6)
          it = good_arp(16'($urandom_range(1, 2)), ips[$urandom_range(0, 7)],
                        {16'($urandom), 32'($urandom)},
                        ($urandom_range(0, 1) != 0) ? m_own_ip : ips[$urandom_range(0, 7)]);
        else if (k < 7) begin
          it = good_arp(16'($urandom), $urandom, {16'($urandom), 32'($urandom)}, $urandom);
          it.flen = 11'($urandom);
          it.hwt = $urandom_range(0, 1) ? 16'($urandom) : HW_ETHERNET;
          it.prt = $urandom_range(0, 1) ? 16'($urandom) : PROTO_IPV4;
          it.hwl = $urandom_range(0, 1) ? 8'($urandom) : HW_ADDR_LEN;
          it.prl = $urandom_range(0, 1) ? 8'($urandom) : IP_ADDR_LEN;
        end else if (k < 9)
          it = tick_item();
        else
          it = send_item($urandom, 8'($urandom));            // fresh miss, fills pending
        offer(it);
      end
      wait_idle();
    end

    drained = 1;
    repeat (ITEM_CYCLES) @(negedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("** arp_resolver_cache: PASSED **");
    else
      $display("** arp_resolver_cache: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/arp_pkg.sv
rtl/core/arp_resolver_cache.sv
rtl/core/arp_resolver_cache_checker.sv
verif/testbench.sv
